// ===== rtl/core/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants for the ADSR envelope with VCA
// Register indexes, reset values, stage codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 23;
    localparam int VEL_BITS      = 16;
    localparam int VEL_FRAC_BITS = 15;

    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN = 2'd3;

    localparam logic [21:0] RST_ATTACK  = 22'd175;
    localparam logic [21:0] RST_DECAY   = 22'd87;
    localparam logic [22:0] RST_RELEASE = 23'd350;
    localparam logic [22:0] RST_SUSTAIN = 23'd3355443;

    localparam logic [1:0] STAGE_IDLE    = 2'd0;
    localparam logic [1:0] STAGE_ATTACK  = 2'd1;
    localparam logic [1:0] STAGE_DECAY   = 2'd2;
    localparam logic [1:0] STAGE_RELEASE = 2'd3;

    typedef struct packed {
        logic [21:0] attack_step;
        logic [21:0] decay_step;
        logic [22:0] release_step;
        logic [22:0] sustain_level;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_LEVEL,
        ST_MUL_VEL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic env_load;
        logic mul_level;
        logic mul_vel;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_stall;
    } sts_t;

endpackage

// ===== rtl/core/adsr_cfg.sv =====
// ----------------------------------------------------------------------------
// adsr_cfg: configuration register file
// Holds the attack, decay and release steps and the sustain level, written
// one beat at a time through the configuration channel.
// ----------------------------------------------------------------------------
module adsr_cfg
    import adsr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ATTACK:  cfg_next.attack_step   = cfg_data[21:0];
                REG_DECAY:   cfg_next.decay_step    = cfg_data[21:0];
                REG_RELEASE: cfg_next.release_step  = cfg_data[22:0];
                REG_SUSTAIN: cfg_next.sustain_level = cfg_data[22:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step   <= RST_ATTACK;
            cfg_reg.decay_step    <= RST_DECAY;
            cfg_reg.release_step  <= RST_RELEASE;
            cfg_reg.sustain_level <= RST_SUSTAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/adsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// adsr_ctrl: sequencing controller
// Accepts one tick, then steps the shared multiplier through the level and
// velocity products and loads the output register when it is free.
// ----------------------------------------------------------------------------
module adsr_ctrl
    import adsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_LEVEL;
                end
            end
            ST_MUL_LEVEL: state_next = ST_MUL_VEL;
            ST_MUL_VEL:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!sts.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.env_load = in_valid;
            end
            ST_MUL_LEVEL: cmd.mul_level = 1'b1;
            ST_MUL_VEL:   cmd.mul_vel = 1'b1;
            ST_FINISH:    cmd.out_load = !sts.out_stall;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/adsr_dp.sv =====
// ----------------------------------------------------------------------------
// adsr_dp: envelope and amplifier datapath
// Updates the envelope state on each accepted tick, scales the sample by
// the level and the velocity on one shared multiplier, and holds the result.
// ----------------------------------------------------------------------------
module adsr_dp
    import adsr_pkg::*;
#(
    parameter int SAMPLE_BITS     = 24,
    parameter int LEVEL_FRAC_BITS = 22
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    input  cfg_t                         cfg,
    input  logic                         gate_high,
    input  logic signed [SAMPLE_BITS-1:0] audio_in,
    input  logic [VEL_BITS-1:0]          velocity_gain,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [LEVEL_FRAC_BITS+1:0] envelope_level,
    output logic [1:0]                   stage,
    output logic signed [SAMPLE_BITS-1:0] audio_out
);

    localparam int LB = LEVEL_FRAC_BITS + 2;
    localparam int W  = ((LB > CFG_DATA_BITS) ? LB : CFG_DATA_BITS) + 2;
    localparam int BW = (LB > VEL_BITS + 1) ? LB : VEL_BITS + 1;
    localparam int PW = SAMPLE_BITS + BW;
    localparam int QW = PW + 1;

    localparam logic signed [W-1:0] LVL_ONE  = W'(1) <<< LEVEL_FRAC_BITS;
    localparam logic signed [W-1:0] LVL_HALF = LVL_ONE >>> 1;
    localparam logic signed [W-1:0] LVL_MAX  = (LVL_ONE <<< 1) - W'(1);
    localparam logic signed [W-1:0] LVL_MIN  = ~LVL_MAX;
    localparam logic signed [W-1:0] STEP_MIN = W'(1);
    localparam longint MARGIN_VAL = ((64'd1 << LEVEL_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic signed [W-1:0] SUS_MARGIN = W'(MARGIN_VAL);

    localparam logic signed [QW-1:0] S_MAX  = (QW'(1) <<< (SAMPLE_BITS - 1)) - QW'(1);
    localparam logic signed [QW-1:0] S_MIN  = ~S_MAX;
    localparam logic signed [QW-1:0] RND_LV = QW'(1) <<< (LEVEL_FRAC_BITS - 1);
    localparam logic signed [QW-1:0] RND_VL = QW'(1) <<< (VEL_FRAC_BITS - 1);

    logic signed [LB-1:0]          level_reg;
    logic signed [LB-1:0]          level_next;
    logic                          in_attack_reg;
    logic                          in_attack_next;
    logic                          running_reg;
    logic                          running_next;
    logic                          last_gate_reg;
    logic [1:0]                    stage_reg;
    logic [1:0]                    stage_next;
    logic signed [SAMPLE_BITS-1:0] audio_reg;
    logic [VEL_BITS-1:0]           vel_reg;
    logic signed [PW-1:0]          prod_reg;
    logic                          out_valid_reg;
    logic signed [LB-1:0]          env_out_reg;
    logic [1:0]                    stage_out_reg;
    logic signed [SAMPLE_BITS-1:0] audio_out_reg;

    logic signed [W-1:0] a_raw;
    logic signed [W-1:0] d_raw;
    logic signed [W-1:0] r_raw;
    logic signed [W-1:0] s_raw;
    logic signed [W-1:0] a_eff;
    logic signed [W-1:0] d_eff;
    logic signed [W-1:0] r_eff;
    logic signed [W-1:0] s_eff;
    logic signed [W-1:0] lvl;
    logic signed [W-1:0] sum_a;
    logic signed [W-1:0] sum_d;
    logic signed [W-1:0] sum_r;
    logic signed [W-1:0] sat_a;
    logic signed [W-1:0] sat_d;
    logic signed [W-1:0] sat_r;
    logic                rise;
    logic                att;
    logic                run;

    logic signed [QW-1:0]          q_lv;
    logic signed [QW-1:0]          sh_lv;
    logic signed [SAMPLE_BITS-1:0] t_lv;
    logic signed [QW-1:0]          q_vl;
    logic signed [QW-1:0]          sh_vl;
    logic signed [SAMPLE_BITS-1:0] t_vl;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [BW-1:0]          mul_b;
    logic signed [PW-1:0]          mul_p;

    assign a_raw = signed'(W'(cfg.attack_step));
    assign d_raw = signed'(W'(cfg.decay_step));
    assign r_raw = signed'(W'(cfg.release_step));
    assign s_raw = signed'(W'(cfg.sustain_level));

    assign a_eff = (a_raw < STEP_MIN) ? STEP_MIN : ((a_raw > LVL_HALF) ? LVL_HALF : a_raw);
    assign d_eff = (d_raw > LVL_HALF) ? LVL_HALF : d_raw;
    assign r_eff = (r_raw < STEP_MIN) ? STEP_MIN : ((r_raw > LVL_ONE) ? LVL_ONE : r_raw);
    assign s_eff = (s_raw > LVL_ONE) ? LVL_ONE : s_raw;

    assign lvl   = W'(level_reg);
    assign sum_a = lvl + a_eff;
    assign sum_d = lvl - d_eff;
    assign sum_r = lvl - r_eff;
    assign sat_a = (sum_a > LVL_MAX) ? LVL_MAX : ((sum_a < LVL_MIN) ? LVL_MIN : sum_a);
    assign sat_d = (sum_d > LVL_MAX) ? LVL_MAX : ((sum_d < LVL_MIN) ? LVL_MIN : sum_d);
    assign sat_r = (sum_r > LVL_MAX) ? LVL_MAX : ((sum_r < LVL_MIN) ? LVL_MIN : sum_r);

    assign rise = gate_high && !last_gate_reg;
    assign att  = rise || in_attack_reg;
    assign run  = rise || running_reg;

    always_comb
    begin
        level_next     = level_reg;
        in_attack_next = att;
        running_next   = run;
        stage_next     = STAGE_IDLE;
        if (!run)
        begin
            level_next = '0;
            stage_next = STAGE_IDLE;
        end
        else if (gate_high)
        begin
            if (att)
            begin
                stage_next     = STAGE_ATTACK;
                level_next     = sat_a[LB-1:0];
                in_attack_next = !(sat_a >= LVL_ONE);
            end
            else
            begin
                stage_next = STAGE_DECAY;
                if (lvl <= s_eff + SUS_MARGIN)
                begin
                    level_next = s_eff[LB-1:0];
                end
                else
                begin
                    level_next = sat_d[LB-1:0];
                end
            end
        end
        else
        begin
            stage_next   = STAGE_RELEASE;
            level_next   = sat_r[LB-1:0];
            running_next = !(sat_r <= -r_eff);
        end
    end

    // The first product is rounded and saturated before it feeds the second pass.
    assign q_lv  = QW'(prod_reg) + RND_LV;
    assign sh_lv = q_lv >>> LEVEL_FRAC_BITS;
    assign t_lv  = (sh_lv > S_MAX) ? S_MAX[SAMPLE_BITS-1:0] :
                   ((sh_lv < S_MIN) ? S_MIN[SAMPLE_BITS-1:0] : sh_lv[SAMPLE_BITS-1:0]);

    assign q_vl  = QW'(prod_reg) + RND_VL;
    assign sh_vl = q_vl >>> VEL_FRAC_BITS;
    assign t_vl  = (sh_vl > S_MAX) ? S_MAX[SAMPLE_BITS-1:0] :
                   ((sh_vl < S_MIN) ? S_MIN[SAMPLE_BITS-1:0] : sh_vl[SAMPLE_BITS-1:0]);

    assign mul_a = cmd.mul_vel ? t_lv : audio_reg;
    assign mul_b = cmd.mul_vel ? signed'(BW'(vel_reg)) : BW'(level_reg);
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            in_attack_reg <= 1'b0;
            running_reg   <= 1'b0;
            last_gate_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.env_load)
            begin
                level_reg     <= level_next;
                in_attack_reg <= in_attack_next;
                running_reg   <= running_next;
                last_gate_reg <= gate_high;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.env_load)
        begin
            stage_reg <= stage_next;
            audio_reg <= audio_in;
            vel_reg   <= velocity_gain;
        end
        if (cmd.mul_level || cmd.mul_vel)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.out_load)
        begin
            env_out_reg   <= level_reg;
            stage_out_reg <= stage_reg;
            audio_out_reg <= t_vl;
        end
    end

    assign sts.out_stall  = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign envelope_level = env_out_reg;
    assign stage          = stage_out_reg;
    assign audio_out      = audio_out_reg;

endmodule

// ===== rtl/core/adsr_envelope_with_vca.sv =====
// An accepted tick steps through the level product, the velocity product and the
// output load, with both products formed on the single shared multiplier. The load
// waits while the held result is not yet taken, and no new tick is accepted until then.
// The output register lets the next tick be accepted while a result waits.
// Reset clears the envelope state, the controller and output valid, and loads the
// default attack, decay, release and sustain settings.
// ----------------------------------------------------------------------------
// adsr_envelope_with_vca: ADSR envelope generator with amplifier
// Gate driven attack, decay, sustain and release envelope that scales each
// audio sample by the envelope level and the velocity gain.
// ----------------------------------------------------------------------------
module adsr_envelope_with_vca
    import adsr_pkg::*;
#(
    parameter int SAMPLE_BITS     = 24,
    parameter int LEVEL_FRAC_BITS = 22
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              gate_high,
    input  logic signed [SAMPLE_BITS-1:0]     audio_in,
    input  logic [VEL_BITS-1:0]               velocity_gain,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [LEVEL_FRAC_BITS+1:0] envelope_level,
    output logic [1:0]                        stage,
    output logic signed [SAMPLE_BITS-1:0]     audio_out
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    adsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    adsr_dp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg            (cfg),
        .gate_high      (gate_high),
        .audio_in       (audio_in),
        .velocity_gain  (velocity_gain),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .envelope_level (envelope_level),
        .stage          (stage),
        .audio_out      (audio_out)
    );

endmodule

// ===== verif/adsr_env_checker.sv =====
// ----------------------------------------------------------------------------
// adsr_env_checker: envelope and amplifier prediction for the ADSR block
// Watches the register, tick and result channels, advances its own copy of
// the envelope for every accepted tick beat, and compares each result beat
// field by field against the oldest predicted tick.
// ----------------------------------------------------------------------------
module adsr_env_checker
    import adsr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       gate_high,
    input  logic signed [23:0]         audio_in,
    input  logic [VEL_BITS-1:0]        velocity_gain,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [23:0]         envelope_level,
    input  logic [1:0]                 stage,
    input  logic signed [23:0]         audio_out,
    output int                         mismatch_count,
    output int                         ticks_pending
);

    localparam longint LEVEL_ONE  = 4194304;
    localparam longint LEVEL_HI   = 8388607;
    localparam longint LEVEL_LO   = -8388608;
    localparam longint SAMPLE_HI  = 8388607;
    localparam longint SAMPLE_LO  = -8388608;
    localparam longint SUS_MARGIN = (LEVEL_ONE + 500) / 1000;
    localparam int     LEVEL_FRAC = 22;

    typedef struct packed {
        logic [23:0] level;
        logic [1:0]  stage;
        logic [23:0] sample;
    } tick_t;

    tick_t  expected_ticks[$];
    cfg_t   shadow_cfg;
    longint env;
    bit     attack_phase;
    bit     note_on;
    bit     prev_gate;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint round_shift(input longint p, input int sh);
        return (p + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    task automatic advance_envelope(input logic gate, input logic [23:0] sample,
                                    input logic [15:0] gain, output tick_t want);
        longint atk;
        longint dec;
        longint rel;
        longint sus;
        longint smp;
        longint vel;
        longint amp;
        logic [1:0] st;
        atk = shadow_cfg.attack_step;
        dec = shadow_cfg.decay_step;
        rel = shadow_cfg.release_step;
        sus = shadow_cfg.sustain_level;
        atk = clip(atk, 1, LEVEL_ONE / 2);
        dec = clip(dec, 0, LEVEL_ONE / 2);
        rel = clip(rel, 1, LEVEL_ONE);
        sus = clip(sus, 0, LEVEL_ONE);
        smp = $signed(sample);
        vel = gain;

        if (gate && !prev_gate) begin
            attack_phase = 1'b1;
            note_on      = 1'b1;
        end
        prev_gate = gate;

        if (!note_on) begin
            env = 0;
            st  = STAGE_IDLE;
        end
        else if (gate) begin
            if (attack_phase) begin
                st  = STAGE_ATTACK;
                env = clip(env + atk, LEVEL_LO, LEVEL_HI);
                if (env >= LEVEL_ONE)
                    attack_phase = 1'b0;
            end
            else begin
                st = STAGE_DECAY;
                if (env <= sus + SUS_MARGIN)
                    env = sus;
                else
                    env = clip(env - dec, LEVEL_LO, LEVEL_HI);
            end
        end
        else begin
            st  = STAGE_RELEASE;
            env = clip(env - rel, LEVEL_LO, LEVEL_HI);
            if (env <= -rel)
                note_on = 1'b0;
        end

        amp = clip(round_shift(smp * env, LEVEL_FRAC), SAMPLE_LO, SAMPLE_HI);
        amp = clip(round_shift(amp * vel, VEL_FRAC_BITS), SAMPLE_LO, SAMPLE_HI);
        want.level  = env[23:0];
        want.stage  = st;
        want.sample = amp[23:0];
    endtask

    task automatic compare_field(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        tick_t want;
        if (!rst_n) begin
            shadow_cfg     = '{RST_ATTACK, RST_DECAY, RST_RELEASE, RST_SUSTAIN};
            env            = 0;
            attack_phase   = 1'b0;
            note_on        = 1'b0;
            prev_gate      = 1'b0;
            expected_ticks.delete();
            mismatch_count = 0;
            ticks_pending  = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: unexpected result level %0d stage %0d audio_out %0d",
                             $time, envelope_level, stage, audio_out);
                    mismatch_count++;
                end
                else begin
                    want = expected_ticks.pop_front();
                    compare_field("envelope_level", $signed(want.level), envelope_level);
                    compare_field("stage", {30'b0, want.stage}, {30'b0, stage});
                    compare_field("audio_out", $signed(want.sample), audio_out);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ATTACK:  shadow_cfg.attack_step   = cfg_data[21:0];
                    REG_DECAY:   shadow_cfg.decay_step    = cfg_data[21:0];
                    REG_RELEASE: shadow_cfg.release_step  = cfg_data[22:0];
                    REG_SUSTAIN: shadow_cfg.sustain_level = cfg_data[22:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                advance_envelope(gate_high, audio_in, velocity_gain, want);
                expected_ticks.push_back(want);
            end
            ticks_pending = expected_ticks.size();
        end
    end

endmodule

// ===== verif/tb_adsr_envelope_with_vca.sv =====
// ----------------------------------------------------------------------------
// tb_adsr_envelope_with_vca: stimulus and verdict for the ADSR envelope block
// Drives directed envelope walks and random notes through several register
// settings and idle patterns; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_with_vca;
    import adsr_pkg::*;

    typedef enum int {
        SET_FLOOR,
        SET_UNIT_STEP,
        SET_CEILING,
        SET_RAW,
        SET_MODERATE
    } setting_t;

    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_TICKS  = 130;

    logic                       clk;
    logic                       rst_n         = 1'b0;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index     = REG_ATTACK;
    logic [CFG_DATA_BITS-1:0]   cfg_data      = '0;
    logic                       in_valid      = 1'b0;
    logic                       in_ready;
    logic                       gate_high     = 1'b0;
    logic signed [23:0]         audio_in      = '0;
    logic [VEL_BITS-1:0]        velocity_gain = '0;
    logic                       out_valid;
    logic                       out_ready     = 1'b0;
    logic signed [23:0]         envelope_level;
    logic [1:0]                 stage;
    logic signed [23:0]         audio_out;
    int                         mismatch_count;
    int                         ticks_pending;
    int                         send_idle_pct = 38;
    int                         take_idle_pct = 71;
    int                         stall_cycles  = 0;
    int                         ticks_sent    = 0;

    adsr_envelope_with_vca dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .gate_high      (gate_high),
        .audio_in       (audio_in),
        .velocity_gain  (velocity_gain),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .envelope_level (envelope_level),
        .stage          (stage),
        .audio_out      (audio_out)
    );

    adsr_env_checker env_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .gate_high      (gate_high),
        .audio_in       (audio_in),
        .velocity_gain  (velocity_gain),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .envelope_level (envelope_level),
        .stage          (stage),
        .audio_out      (audio_out),
        .mismatch_count (mismatch_count),
        .ticks_pending  (ticks_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
            (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_tick(input logic g, input logic [23:0] smp, input logic [15:0] vel);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        gate_high     <= g;
        audio_in      <= smp;
        velocity_gain <= vel;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (ticks_pending != 0);
    endtask

    task automatic load_settings(input setting_t kind);
        logic [22:0] atk;
        logic [22:0] dec;
        logic [22:0] rel;
        logic [22:0] sus;
        case (kind)
            SET_FLOOR:
            begin
                atk = '0;
                dec = '0;
                rel = '0;
                sus = '0;
            end
            SET_UNIT_STEP:
            begin
                atk = 23'd1;
                dec = 23'd0;
                rel = 23'd1;
                sus = 23'd4194304;
            end
            SET_CEILING:
            begin
                atk = 23'h7FFFFF;
                dec = 23'h7FFFFF;
                rel = 23'h7FFFFF;
                sus = 23'h7FFFFF;
            end
            SET_RAW:
            begin
                atk = 23'($urandom);
                dec = 23'($urandom);
                rel = 23'($urandom);
                sus = 23'($urandom);
            end
            default:
            begin
                atk = 23'($urandom_range(150000, 2097152));
                dec = 23'($urandom_range(0, 700000));
                rel = 23'($urandom_range(150000, 4194304));
                sus = 23'($urandom_range(0, 4194304));
            end
        endcase
        wait_drained();
        write_reg(REG_ATTACK, atk);
        write_reg(REG_DECAY, dec);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_SUSTAIN, sus);
        cfg_valid <= 1'b0;
    endtask

    task automatic play_note(input int hold, input int rest);
        repeat (hold) send_tick(1'b1, rand_sample(), rand_gain());
        repeat (rest) send_tick(1'b0, rand_sample(), rand_gain());
    endtask

    initial
    begin
        int       phase_start;
        setting_t kind;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a short note that ends its release exactly at minus one step.
        send_tick(1'b0, 24'h7FFFFF, 16'hFFFF);
        send_tick(1'b1, 24'h7FFFFF, 16'hFFFF);
        send_tick(1'b1, 24'h800000, 16'h8000);
        send_tick(1'b0, 24'h800000, 16'h0000);
        send_tick(1'b0, 24'h000000, 16'hFFFF);
        send_tick(1'b0, 24'h7FFFFF, 16'hFFFF);

        // Fastest steps with masked and capped values, sustain at one quarter.
        wait_drained();
        write_reg(REG_ATTACK, 23'h7FFFFF);
        write_reg(REG_DECAY, 23'd2097152);
        write_reg(REG_RELEASE, 23'h7FFFFF);
        write_reg(REG_SUSTAIN, 23'd1048576);
        cfg_valid <= 1'b0;
        send_tick(1'b1, 24'h7FFFFF, 16'hFFFF);
        send_tick(1'b1, 24'h800000, 16'hFFFF);
        send_tick(1'b1, 24'h7FFFFF, 16'h8000);
        send_tick(1'b1, 24'h7FFFFF, 16'h0000);
        send_tick(1'b1, 24'h800000, 16'h8000);
        send_tick(1'b1, 24'h555555, 16'hAAAA);
        send_tick(1'b0, 24'hAAAAAA, 16'h5555);
        send_tick(1'b0, 24'h800000, 16'hFFFF);
        send_tick(1'b0, 24'h7FFFFF, 16'hFFFF);
        send_tick(1'b1, 24'h000001, 16'h8000);
        send_tick(1'b0, 24'h000001, 16'h8000);
        send_tick(1'b1, 24'h7FFFFF, 16'hFFFF);
        send_tick(1'b1, 24'hFFFFFF, 16'h8000);
        send_tick(1'b1, 24'h123456, 16'h7FFF);
        send_tick(1'b1, 24'hEDCBA9, 16'h0001);
        send_tick(1'b0, 24'h400000, 16'hC000);

        for (int regime = 0; regime < 3; regime++)
        begin
            if (regime == 1)
            begin
                send_idle_pct = 71;
                take_idle_pct = 38;
            end
            else if (regime == 2)
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            for (int p = 0; p < 4; p++)
            begin
                if (regime * 4 + p == 0)
                    kind = SET_FLOOR;
                else if (regime * 4 + p == 5)
                    kind = SET_CEILING;
                else if (regime * 4 + p == 9)
                    kind = SET_UNIT_STEP;
                else if (p == 3)
                    kind = SET_RAW;
                else
                    kind = SET_MODERATE;
                load_settings(kind);
                phase_start = ticks_sent;
                while (ticks_sent - phase_start < PHASE_TICKS)
                begin
                    if ($urandom_range(5) == 0)
                        repeat ($urandom_range(1, 4))
                            send_tick(1'($urandom_range(1)), rand_sample(), rand_gain());
                    play_note($urandom_range(1, 60), $urandom_range(1, 40));
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && ticks_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
